// ===== design/ypc_pkg.sv =====
// Shared constants, types and the angle table of the camera pose unit.
package ypc_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CORDIC_ITERS     = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
  localparam int ITER_W           = $clog2(CORDIC_ITERS);

  localparam int POS_W   = 32;
  localparam int VIEW_W  = 16;
  localparam int SENS_W  = 16;
  localparam int AMT_W   = 16;
  localparam int DELTA_W = 12;
  localparam int XY_W    = 32;  // CORDIC x/y, Q2.30
  localparam int ANG_W   = 26;  // CORDIC angle, Q16.16 degrees
  localparam int YAW_W   = 25;  // [0, 360) degrees
  localparam int PITCH_W = 24;  // [-89, 89] degrees
  localparam int ACC_W   = 30;  // angle sums before wrap/clamp
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;

  localparam logic signed [ACC_W-1:0] FULL_TURN   = ACC_W'(360 * 65536);
  localparam logic signed [ACC_W-1:0] HALF_TURN   = ACC_W'(180 * 65536);
  localparam logic signed [ACC_W-1:0] PITCH_LIMIT = ACC_W'(89 * 65536);

  localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(180 * 65536);

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [POS_W-1:0]  POS_Z_RESET  = 32'sd327680;
  localparam logic [YAW_W-1:0]         YAW_RESET    = YAW_W'(270 * 65536);
  localparam logic signed [VIEW_W-1:0] VIEW_ONE     = 16'sd16384;
  localparam logic [SENS_W-1:0]        SENS_RESET   = 16'd6554;

  typedef enum logic [1:0] {
    KIND_FWD   = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_UP    = 2'd2,
    KIND_ROT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [XY_W-1:0] sin_v;
    logic signed [XY_W-1:0] cos_v;
  } cordic_rsp_t;

  // atan(2^-i) in Q16.16 degrees, rounded to nearest
  function automatic logic [22:0] atan_deg(input logic [4:0] idx);
    logic [22:0] r;
    unique case (idx)
      5'd0:    r = 23'd2949120;
      5'd1:    r = 23'd1740967;
      5'd2:    r = 23'd919879;
      5'd3:    r = 23'd466945;
      5'd4:    r = 23'd234379;
      5'd5:    r = 23'd117304;
      5'd6:    r = 23'd58666;
      5'd7:    r = 23'd29335;
      5'd8:    r = 23'd14668;
      5'd9:    r = 23'd7334;
      5'd10:   r = 23'd3667;
      5'd11:   r = 23'd1833;
      5'd12:   r = 23'd917;
      5'd13:   r = 23'd458;
      5'd14:   r = 23'd229;
      5'd15:   r = 23'd115;
      5'd16:   r = 23'd57;
      5'd17:   r = 23'd29;
      5'd18:   r = 23'd14;
      5'd19:   r = 23'd7;
      5'd20:   r = 23'd4;
      5'd21:   r = 23'd2;
      5'd22:   r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ypc_if.sv =====
// Item channels of the camera pose unit: event in, pose out.
interface ypc_cmd_if;
  logic                                  valid;
  logic                                  ready;
  ypc_pkg::kind_t                        kind;
  logic signed [ypc_pkg::AMT_W-1:0]      amount;
  logic signed [ypc_pkg::DELTA_W-1:0]    delta_x;
  logic signed [ypc_pkg::DELTA_W-1:0]    delta_y;

  modport source (output valid, kind, amount, delta_x, delta_y, input ready);
  modport sink   (input valid, kind, amount, delta_x, delta_y, output ready);
endinterface

interface ypc_pose_if;
  logic                              valid;
  logic                              ready;
  logic signed [ypc_pkg::POS_W-1:0]  eye_x;
  logic signed [ypc_pkg::POS_W-1:0]  eye_y;
  logic signed [ypc_pkg::POS_W-1:0]  eye_z;
  logic signed [ypc_pkg::VIEW_W-1:0] view_x;
  logic signed [ypc_pkg::VIEW_W-1:0] view_y;
  logic signed [ypc_pkg::VIEW_W-1:0] view_z;

  modport source (output valid, eye_x, eye_y, eye_z, view_x, view_y, view_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, view_x, view_y, view_z, output ready);
endinterface

// ===== design/ypc_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
module ypc_mul (
  input  logic                               clk,
  input  logic signed [ypc_pkg::MUL_W-1:0]   a,
  input  logic signed [ypc_pkg::MUL_W-1:0]   b,
  output logic signed [ypc_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/ypc_cordic.sv =====
// Iterative CORDIC sine/cosine, one micro-rotation per cycle.
module ypc_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  ypc_pkg::cordic_req_t req,
  output ypc_pkg::cordic_rsp_t rsp
);

  localparam logic [ypc_pkg::ITER_W-1:0] LAST_ITER = ypc_pkg::ITER_W'(ypc_pkg::CORDIC_ITERS - 1);

  logic                            busy;
  logic                            done;
  logic                            neg;
  logic [ypc_pkg::ITER_W-1:0]      i;
  logic signed [ypc_pkg::XY_W-1:0] x;
  logic signed [ypc_pkg::XY_W-1:0] y;
  logic signed [ypc_pkg::ANG_W-1:0] z;

  logic signed [ypc_pkg::ANG_W-1:0] ang_fold;
  logic                             neg_in;
  logic signed [ypc_pkg::XY_W-1:0]  step_x;
  logic signed [ypc_pkg::XY_W-1:0]  step_y;
  logic signed [ypc_pkg::ANG_W-1:0] at;

  // bring the angle into [-90, 90]; a half turn negates both results
  always_comb begin
    ang_fold = req.angle;
    neg_in   = 1'b0;
    if (req.angle > ypc_pkg::ANG_QUARTER) begin
      ang_fold = req.angle - ypc_pkg::ANG_HALF;
      neg_in   = 1'b1;
    end else if (req.angle < -ypc_pkg::ANG_QUARTER) begin
      ang_fold = req.angle + ypc_pkg::ANG_HALF;
      neg_in   = 1'b1;
    end
  end

  always_comb begin
    step_x = y >>> i;
    step_y = x >>> i;
    at     = $signed(ypc_pkg::ANG_W'(ypc_pkg::atan_deg(5'(i))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          x    <= ypc_pkg::CORDIC_GAIN;
          y    <= '0;
          z    <= ang_fold;
          i    <= '0;
          neg  <= neg_in;
        end
      end else begin
        if (!z[ypc_pkg::ANG_W-1]) begin
          x <= x - step_x;
          y <= y + step_y;
          z <= z - at;
        end else begin
          x <= x + step_x;
          y <= y - step_y;
          z <= z + at;
        end
        if (i == LAST_ITER) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.cos_v = neg ? -x : x;
  assign rsp.sin_v = neg ? -y : y;

endmodule

// ===== design/yaw_pitch_camera_update.sv =====
// Top level of the fly-camera pose unit: sequencer, pose state and output register.
//
// Keeps a camera position (Q16.16), yaw/pitch (Q16.16 degrees) and a unit view
// vector (Q1.14). Each event item gives one pose item. Forward and right moves
// run through one shared 32x32 multiplier, one registered product per axis
// (forward: x, y, z; right: x and z); an up move adds the shifted amount to y
// without a multiply. A rotate scales the deltas (2 multiplies), wraps yaw by
// repeated +-360 steps, then uses the one CORDIC unit twice in turn, yaw then
// pitch, and two more multiplies for the view vector. One event is in flight at
// a time; cmd.ready is high whenever the sequencer is idle, also while a pose
// still waits to be taken. The user must write sensitivity on cfg_write only
// while the unit is idle; the block itself does not enforce it.
module yaw_pitch_camera_update (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [ypc_pkg::SENS_W-1:0]   cfg_data,
  ypc_cmd_if.sink                      cmd,
  ypc_pose_if.source                   pose
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOVE_MUL,
    S_MOVE_ACC,
    S_UP,
    S_ROT_MX,
    S_ROT_MY,
    S_ROT_PITCH,
    S_ROT_WRAP,
    S_COR_YAW,
    S_COR_PITCH,
    S_VIEW_MX,
    S_VIEW_MZ,
    S_VIEW_Z,
    S_OUT
  } state_t;

  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;
  localparam logic signed [ypc_pkg::PROD_W-1:0] VIEW_RND = 64'sd35184372088832; // 2^45

  state_t                                state;
  logic [ypc_pkg::SENS_W-1:0]            sens;
  ypc_pkg::kind_t                        kind_q;
  logic signed [ypc_pkg::AMT_W-1:0]      amt_q;
  logic signed [ypc_pkg::DELTA_W-1:0]    dx_q;
  logic signed [ypc_pkg::DELTA_W-1:0]    dy_q;
  logic [1:0]                            axis;

  logic signed [ypc_pkg::POS_W-1:0]      pos [3];
  logic signed [ypc_pkg::VIEW_W-1:0]     view [3];
  logic [ypc_pkg::YAW_W-1:0]             yaw;
  logic signed [ypc_pkg::PITCH_W-1:0]    pitch;
  logic signed [ypc_pkg::ACC_W-1:0]      yaw_acc;
  logic signed [ypc_pkg::XY_W-1:0]       sy, cy, sp, cp;

  logic                                  out_valid;
  logic signed [ypc_pkg::POS_W-1:0]      res_eye_x, res_eye_y, res_eye_z;
  logic signed [ypc_pkg::VIEW_W-1:0]     res_view_x, res_view_y, res_view_z;

  logic signed [ypc_pkg::MUL_W-1:0]      mul_a, mul_b;
  logic signed [ypc_pkg::PROD_W-1:0]     mul_p;
  ypc_pkg::cordic_req_t                  cor_req;
  ypc_pkg::cordic_rsp_t                  cor_rsp;

  logic signed [ypc_pkg::VIEW_W-1:0]     comp;
  logic signed [ypc_pkg::PROD_W-1:0]     move_rnd;
  logic signed [33:0]                    move_sum;
  logic signed [33:0]                    up_sum;
  logic signed [ypc_pkg::ACC_W-1:0]      pitch_sum;
  logic signed [ypc_pkg::ACC_W-1:0]      pitch_new;
  logic signed [ypc_pkg::PROD_W-1:0]     view_rnd;
  logic signed [ypc_pkg::PROD_W-1:0]     vy_rnd;
  logic                                  yaw_in_range;

  function automatic logic signed [ypc_pkg::POS_W-1:0] sat_pos(input logic signed [33:0] v);
    logic signed [ypc_pkg::POS_W-1:0] r;
    if (v > POS_MAX) r = POS_MAX[ypc_pkg::POS_W-1:0];
    else if (v < POS_MIN) r = POS_MIN[ypc_pkg::POS_W-1:0];
    else r = v[ypc_pkg::POS_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ypc_pkg::VIEW_W-1:0] clamp_view(
    input logic signed [ypc_pkg::PROD_W-1:0] v
  );
    logic signed [ypc_pkg::VIEW_W-1:0] r;
    if (v > ypc_pkg::PROD_W'(ypc_pkg::VIEW_ONE)) r = ypc_pkg::VIEW_ONE;
    else if (v < -ypc_pkg::PROD_W'(ypc_pkg::VIEW_ONE)) r = -ypc_pkg::VIEW_ONE;
    else r = v[ypc_pkg::VIEW_W-1:0];
    return r;
  endfunction

  ypc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ypc_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cor_req),
    .rsp (cor_rsp)
  );

  // right move walks along (-view_z, 0, view_x)
  always_comb begin
    if (kind_q == ypc_pkg::KIND_RIGHT) begin
      comp = (axis == 2'd0) ? -view[2] : view[0];
    end else begin
      comp = view[axis];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MOVE_MUL: begin
        mul_a = ypc_pkg::MUL_W'(comp);
        mul_b = ypc_pkg::MUL_W'(amt_q);
      end
      S_ROT_MX: begin
        mul_a = ypc_pkg::MUL_W'(dx_q);
        mul_b = $signed(ypc_pkg::MUL_W'(sens));
      end
      S_ROT_MY: begin
        mul_a = ypc_pkg::MUL_W'(dy_q);
        mul_b = $signed(ypc_pkg::MUL_W'(sens));
      end
      S_VIEW_MX: begin
        mul_a = cy;
        mul_b = cp;
      end
      S_VIEW_MZ: begin
        mul_a = sy;
        mul_b = cp;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    move_rnd  = (mul_p + 64'sd32) >>> 6;
    move_sum  = 34'(pos[axis]) + 34'(move_rnd);
    up_sum    = 34'(pos[1]) + (34'(amt_q) <<< 8);
    pitch_sum = ypc_pkg::ACC_W'(pitch) + $signed(mul_p[ypc_pkg::ACC_W-1:0]);
    if (pitch_sum > ypc_pkg::PITCH_LIMIT) pitch_new = ypc_pkg::PITCH_LIMIT;
    else if (pitch_sum < -ypc_pkg::PITCH_LIMIT) pitch_new = -ypc_pkg::PITCH_LIMIT;
    else pitch_new = pitch_sum;
    view_rnd  = (mul_p + VIEW_RND) >>> 46;
    vy_rnd    = (ypc_pkg::PROD_W'(sp) + 64'sd32768) >>> 16;
    yaw_in_range = !yaw_acc[ypc_pkg::ACC_W-1] && (yaw_acc < ypc_pkg::FULL_TURN);
  end

  // yaw goes to the CORDIC as (-180, 180]; pitch follows once yaw is done
  always_comb begin
    cor_req.start = 1'b0;
    cor_req.angle = ypc_pkg::ANG_W'(pitch);
    if (state == S_ROT_WRAP) begin
      cor_req.start = yaw_in_range;
      cor_req.angle = (yaw_acc > ypc_pkg::HALF_TURN)
                    ? ypc_pkg::ANG_W'(yaw_acc - ypc_pkg::FULL_TURN)
                    : ypc_pkg::ANG_W'(yaw_acc);
    end else if (state == S_COR_YAW) begin
      cor_req.start = cor_rsp.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sens      <= ypc_pkg::SENS_RESET;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= ypc_pkg::POS_Z_RESET;
      view[0]   <= '0;
      view[1]   <= '0;
      view[2]   <= -ypc_pkg::VIEW_ONE;
      yaw       <= ypc_pkg::YAW_RESET;
      pitch     <= '0;
      axis      <= '0;
    end else begin
      if (cfg_write) begin
        sens <= cfg_data;
      end
      // output register loads from S_OUT once free, else drains on ready
      if (state == S_OUT && (!out_valid || pose.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && pose.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind_q <= cmd.kind;
            amt_q  <= cmd.amount;
            dx_q   <= cmd.delta_x;
            dy_q   <= cmd.delta_y;
            axis   <= '0;
            unique case (cmd.kind)
              ypc_pkg::KIND_FWD,
              ypc_pkg::KIND_RIGHT: state <= S_MOVE_MUL;
              ypc_pkg::KIND_UP:    state <= S_UP;
              ypc_pkg::KIND_ROT:   state <= S_ROT_MX;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_MOVE_MUL: state <= S_MOVE_ACC;
        S_MOVE_ACC: begin
          pos[axis] <= sat_pos(move_sum);
          if (axis == 2'd2) begin
            state <= S_OUT;
          end else begin
            axis  <= (kind_q == ypc_pkg::KIND_RIGHT) ? 2'd2 : axis + 2'd1;
            state <= S_MOVE_MUL;
          end
        end
        S_UP: begin
          pos[1] <= sat_pos(up_sum);
          state  <= S_OUT;
        end
        S_ROT_MX: state <= S_ROT_MY;
        S_ROT_MY: begin
          yaw_acc <= $signed(ypc_pkg::ACC_W'(yaw)) + $signed(mul_p[ypc_pkg::ACC_W-1:0]);
          state   <= S_ROT_PITCH;
        end
        S_ROT_PITCH: begin
          pitch <= pitch_new[ypc_pkg::PITCH_W-1:0];
          state <= S_ROT_WRAP;
        end
        S_ROT_WRAP: begin
          if (yaw_acc[ypc_pkg::ACC_W-1]) begin
            yaw_acc <= yaw_acc + ypc_pkg::FULL_TURN;
          end else if (!yaw_in_range) begin
            yaw_acc <= yaw_acc - ypc_pkg::FULL_TURN;
          end else begin
            yaw   <= yaw_acc[ypc_pkg::YAW_W-1:0];
            state <= S_COR_YAW;
          end
        end
        S_COR_YAW: begin
          if (cor_rsp.done) begin
            sy    <= cor_rsp.sin_v;
            cy    <= cor_rsp.cos_v;
            state <= S_COR_PITCH;
          end
        end
        S_COR_PITCH: begin
          if (cor_rsp.done) begin
            sp    <= cor_rsp.sin_v;
            cp    <= cor_rsp.cos_v;
            state <= S_VIEW_MX;
          end
        end
        S_VIEW_MX: state <= S_VIEW_MZ;
        S_VIEW_MZ: begin
          view[0] <= clamp_view(view_rnd);
          view[1] <= clamp_view(vy_rnd);
          state   <= S_VIEW_Z;
        end
        S_VIEW_Z: begin
          view[2] <= clamp_view(view_rnd);
          state   <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || pose.ready) begin
            res_eye_x  <= pos[0];
            res_eye_y  <= pos[1];
            res_eye_z  <= pos[2];
            res_view_x <= view[0];
            res_view_y <= view[1];
            res_view_z <= view[2];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready   = (state == S_IDLE);
  assign pose.valid  = out_valid;
  assign pose.eye_x  = res_eye_x;
  assign pose.eye_y  = res_eye_y;
  assign pose.eye_z  = res_eye_z;
  assign pose.view_x = res_view_x;
  assign pose.view_y = res_view_y;
  assign pose.view_z = res_view_z;

endmodule

// ===== design/ypc_checker.sv =====
// Port-level checks of the camera pose unit, bound to the top level.
module ypc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic                              pose_valid,
  input logic                              pose_ready,
  input logic signed [ypc_pkg::POS_W-1:0]  pose_eye_x,
  input logic signed [ypc_pkg::VIEW_W-1:0] pose_view_x
);

  // one event at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("item accepted while previous item still in progress");

  // a pose cannot appear the cycle right after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !$rose(pose_valid))
    else $error("pose item appeared too early");

  // a new pose is only loaded while the sequencer is busy
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> !$past(cmd_ready))
    else $error("pose item loaded while sequencer idle");

  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    (pose_valid && !pose_ready) |=> (pose_valid && $stable(pose_eye_x)))
    else $error("stalled pose item changed");

  a_view_range: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> (pose_view_x <= 16'sd16384 && pose_view_x >= -16'sd16384))
    else $error("view component out of unit range");

endmodule

bind yaw_pitch_camera_update ypc_checker u_ypc_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .pose_valid  (pose.valid),
  .pose_ready  (pose.ready),
  .pose_eye_x  (pose.eye_x),
  .pose_view_x (pose.view_x)
);

// ===== verif/ypc_pose_checker.sv =====
// Pose checker: predicts each pose item from the accepted events and compares it.
module ypc_pose_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [ypc_pkg::SENS_W-1:0] cfg_data,
  ypc_cmd_if                         cmd,
  ypc_pose_if                        pose,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ypc_pkg::*;

  localparam longint DEG       = 65536;
  localparam longint TURN      = 360 * DEG;
  localparam longint HALF      = 180 * DEG;
  localparam longint QUARTER   = 90 * DEG;
  localparam longint PITCH_MAX = 89 * DEG;
  localparam longint GAIN      = 652032874;
  localparam longint UNIT      = 16384;
  localparam longint RND46     = longint'(1) << 45;
  localparam longint RND16     = longint'(1) << 15;

  // atan(2^-i) in Q16.16 degrees
  localparam longint ATAN_Q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  eye_x;
    logic signed [POS_W-1:0]  eye_y;
    logic signed [POS_W-1:0]  eye_z;
    logic signed [VIEW_W-1:0] view_x;
    logic signed [VIEW_W-1:0] view_y;
    logic signed [VIEW_W-1:0] view_z;
  } pose_t;

  logic signed [POS_W-1:0]   eye [3];
  logic signed [VIEW_W-1:0]  view [3];
  logic [YAW_W-1:0]          yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic [SENS_W-1:0]         sens;
  pose_t                     expected_poses [$];

  function automatic longint saturate32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  // Q1.14 times Q8.8, rounded to Q16.16
  function automatic longint scale_move(longint c, longint a);
    return (c * a + 32) >>> 6;
  endfunction

  function automatic void sin_cos_deg(input longint ang, output longint s, output longint c);
    longint x, y, z, dxs, dys;
    bit     flip;
    int     i;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (ang > QUARTER) begin
      ang -= HALF;
      flip = 1'b1;
    end else if (ang < -QUARTER) begin
      ang += HALF;
      flip = 1'b1;
    end
    z = ang;
    for (i = 0; i < CORDIC_ITERS; i++) begin
      dxs = y >>> i;
      dys = x >>> i;
      if (z >= 0) begin
        x -= dxs;
        y += dys;
        z -= ATAN_Q16[i];
      end else begin
        x += dxs;
        y -= dys;
        z += ATAN_Q16[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t next_pose(kind_t k, logic signed [AMT_W-1:0] amt_f,
                                      logic signed [DELTA_W-1:0] dx_f,
                                      logic signed [DELTA_W-1:0] dy_f);
    longint amt, dx, dy, yw, pt, s, a, sy, cy, sp, cp;
    pose_t  r;
    amt = longint'(amt_f);
    dx  = longint'(dx_f);
    dy  = longint'(dy_f);
    s   = longint'(sens);
    case (k)
      KIND_FWD: begin
        for (int i = 0; i < 3; i++)
          eye[i] = POS_W'(saturate32(longint'(eye[i])
                                     + scale_move(longint'(view[i]), amt)));
      end
      KIND_RIGHT: begin
        // horizontal right vector is (-view_z, 0, view_x)
        eye[0] = POS_W'(saturate32(longint'(eye[0]) + scale_move(-longint'(view[2]), amt)));
        eye[2] = POS_W'(saturate32(longint'(eye[2]) + scale_move(longint'(view[0]), amt)));
      end
      KIND_UP: begin
        eye[1] = POS_W'(saturate32(longint'(eye[1]) + amt * 256));
      end
      default: begin
        yw = longint'(yaw);
        pt = longint'(pitch);
        yw = (yw + dx * s) % TURN;
        pt = pt + dy * s;
        if (yw < 0) yw += TURN;
        if (pt > PITCH_MAX) pt = PITCH_MAX;
        if (pt < -PITCH_MAX) pt = -PITCH_MAX;
        yaw   = YAW_W'(yw);
        pitch = PITCH_W'(pt);
        a = yw;
        if (a > HALF) a -= TURN;
        sin_cos_deg(a, sy, cy);
        sin_cos_deg(pt, sp, cp);
        view[0] = VIEW_W'(clamp_unit((cy * cp + RND46) >>> 46));
        view[1] = VIEW_W'(clamp_unit((sp + RND16) >>> 16));
        view[2] = VIEW_W'(clamp_unit((sy * cp + RND46) >>> 46));
      end
    endcase
    r = '{eye[0], eye[1], eye[2], view[0], view[1], view[2]};
    return r;
  endfunction

  always @(posedge clk) begin
    pose_t got, want;
    if (rst) begin
      eye[0]  = '0;
      eye[1]  = '0;
      eye[2]  = 32'sd327680;
      view[0] = '0;
      view[1] = '0;
      view[2] = -16'sd16384;
      yaw     = YAW_W'(270 * 65536);
      pitch   = '0;
      sens    = 16'd6554;
      expected_poses.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) sens = cfg_data;
      if (pose.valid && pose.ready) begin
        got = '{pose.eye_x, pose.eye_y, pose.eye_z, pose.view_x, pose.view_y, pose.view_z};
        if (expected_poses.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: pose item with none expected: eye=(%0d,%0d,%0d) view=(%0d,%0d,%0d)",
                     $realtime, got.eye_x, got.eye_y, got.eye_z,
                     got.view_x, got.view_y, got.view_z);
          fail_count++;
        end else begin
          want = expected_poses.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: pose mismatch: exp eye=(%0d,%0d,%0d) view=(%0d,%0d,%0d)",
                       $realtime, want.eye_x, want.eye_y, want.eye_z,
                       want.view_x, want.view_y, want.view_z);
              $display("%0t:                got eye=(%0d,%0d,%0d) view=(%0d,%0d,%0d)",
                       $realtime, got.eye_x, got.eye_y, got.eye_z,
                       got.view_x, got.view_y, got.view_z);
            end
            fail_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready)
        expected_poses.push_back(next_pose(cmd.kind, cmd.amount, cmd.delta_x, cmd.delta_y));
    end
    pending = expected_poses.size();
  end

endmodule

// ===== verif/yaw_pitch_camera_update_tb.sv =====
// Testbench top of the camera pose unit: clock, reset, event stimulus and verdict.
module yaw_pitch_camera_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ypc_pkg::*;

  localparam int CYCLE_LIMIT      = 600000;
  localparam int BURST_LEN        = 280;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int DRAIN_CYCLES     = 100;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [SENS_W-1:0] cfg_data;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  bit                quiet;

  ypc_cmd_if  cmd_ch ();
  ypc_pose_if pose_ch ();

  yaw_pitch_camera_update dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .pose      (pose_ch)
  );

  ypc_pose_checker pose_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .cmd        (cmd_ch),
    .pose       (pose_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [AMT_W-1:0] rnd_amt();
    return AMT_W'($urandom);
  endfunction

  function automatic logic signed [DELTA_W-1:0] rnd_delta();
    return DELTA_W'($urandom);
  endfunction

  task automatic send_event(kind_t k, logic signed [AMT_W-1:0] amt,
                            logic signed [DELTA_W-1:0] dx, logic signed [DELTA_W-1:0] dy);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.kind    <= k;
    cmd_ch.amount  <= amt;
    cmd_ch.delta_x <= dx;
    cmd_ch.delta_y <= dy;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // hold off the sender until every pose item has come back
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_sens(logic [SENS_W-1:0] v);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_random();
    kind_t                     k;
    logic signed [AMT_W-1:0]   a;
    logic signed [DELTA_W-1:0] dx, dy;
    if ($urandom_range(0, 39) == 0) quiet = ~quiet;
    k = kind_t'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      a  = rnd_amt();
      dx = rnd_delta();
      dy = rnd_delta();
    end else begin
      a  = AMT_W'($urandom_range(0, 4095) - 2048);
      dx = DELTA_W'($urandom_range(0, 255) - 128);
      dy = DELTA_W'($urandom_range(0, 255) - 128);
    end
    if ($urandom_range(0, 63) == 0) wait_idle();
    send_event(k, a, dx, dy);
  endtask

  // stall the pose channel for a random number of cycles per item
  initial begin
    int stall;
    pose_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        pose_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pose_ch.ready <= 1'b1;
      do @(posedge clk); while (!pose_ch.valid);
    end
  end

  initial begin
    logic [SENS_W-1:0] v;
    cfg_write       = 1'b0;
    cfg_data        = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.kind     = KIND_FWD;
    cmd_ch.amount   = '0;
    cmd_ch.delta_x  = '0;
    cmd_ch.delta_y  = '0;
    quiet           = 1'b0;
    rst             = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // moves from the reset pose, unused fields random
    send_event(KIND_FWD,   16'sh7FFF, rnd_delta(), rnd_delta());
    send_event(KIND_FWD,   16'sh8000, rnd_delta(), rnd_delta());
    send_event(KIND_RIGHT, 16'sh7FFF, rnd_delta(), rnd_delta());
    send_event(KIND_RIGHT, 16'sh8000, rnd_delta(), rnd_delta());
    send_event(KIND_UP,    16'sh7FFF, rnd_delta(), rnd_delta());
    send_event(KIND_UP,    16'sh8000, rnd_delta(), rnd_delta());
    send_event(KIND_UP,    16'sh0000, rnd_delta(), rnd_delta());
    send_event(KIND_FWD,   16'sh0001, rnd_delta(), rnd_delta());
    send_event(KIND_RIGHT, 16'shFFFF, rnd_delta(), rnd_delta());

    // view still along -z: drive z to the top limit, then x to the bottom limit
    repeat (BURST_LEN)
      send_event(KIND_FWD, AMT_W'(0 - $urandom_range(31000, 32768)),
                 rnd_delta(), rnd_delta());
    repeat (BURST_LEN)
      send_event(KIND_RIGHT, AMT_W'(0 - $urandom_range(31000, 32768)),
                 rnd_delta(), rnd_delta());
    send_event(KIND_FWD, 16'sh4000, rnd_delta(), rnd_delta());
    send_event(KIND_RIGHT, 16'sh4000, rnd_delta(), rnd_delta());

    // rotations: yaw wrap both ways, pitch clamp both ways
    send_event(KIND_ROT, rnd_amt(), 12'sh7FF, 12'sh000);
    send_event(KIND_ROT, rnd_amt(), 12'sh800, 12'sh000);
    send_event(KIND_ROT, rnd_amt(), 12'sh800, 12'sh000);
    send_event(KIND_ROT, rnd_amt(), 12'sh000, 12'sh7FF);
    send_event(KIND_FWD, 16'sd20000, rnd_delta(), rnd_delta());
    send_event(KIND_ROT, rnd_amt(), 12'sh000, 12'sh800);
    send_event(KIND_RIGHT, -16'sd20000, rnd_delta(), rnd_delta());
    send_event(KIND_ROT, rnd_amt(), 12'sh000, 12'sh000);
    send_event(KIND_ROT, rnd_amt(), 12'sd300, 12'sd100);
    send_event(KIND_FWD, 16'sd256, rnd_delta(), rnd_delta());

    repeat (RANDOM_PER_PHASE) send_random();

    for (int p = 1; p <= 6; p++) begin
      case (p)
        1:       v = 16'hFFFF;
        2:       v = 16'h0000;
        3:       v = 16'h8000;
        4:       v = SENS_W'($urandom);
        5:       v = 16'h0001;
        default: v = 16'd6554;
      endcase
      write_sens(v);
      if (p == 3) begin
        // half a degree per count: pitch lands exactly on the limit and on zero
        send_event(KIND_ROT, rnd_amt(), 12'sd0, 12'sh800);
        send_event(KIND_ROT, rnd_amt(), 12'sd0, 12'sd178);
        send_event(KIND_ROT, rnd_amt(), 12'sd0, 12'sd178);
        send_event(KIND_ROT, rnd_amt(), 12'sd0, -12'sd178);
      end
      repeat (RANDOM_PER_PHASE) send_random();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
